// File: design/lsst_pkg.sv
// ----------------------------------------------------------------------------
// lsst_pkg
// Shared constants for the log-spaced save trigger unit.
// ----------------------------------------------------------------------------
package lsst_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned StepBitsDefault   = 32;

  localparam int unsigned StepW   = 32;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PointW  = 52;
  localparam int unsigned BaseW   = 21;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned InDataW = 80;
  localparam int unsigned OutDataW = 8;

  localparam logic [PointW-1:0] PointOne = 52'h0_0000_0001_0000;
  localparam logic [PointW-1:0] PointMax = '1;
  localparam logic [5:0]        SearchLimit = 6'd32;

  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;

  localparam logic [1:0] ModeLinear  = 2'd0;
  localparam logic [1:0] ModeSemilog = 2'd1;
  localparam logic [1:0] ModeTable   = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgSaveMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLinearPeriod = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLogBlock     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLogBase      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLogEnable    = 3'd4;

endpackage

// File: design/lsst_ram.sv
// ----------------------------------------------------------------------------
// lsst_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/log_spaced_save_trigger_unit.sv
// ----------------------------------------------------------------------------
// log_spaced_save_trigger_unit
// Decides per step tick whether a snapshot is due (linear, semilog or table).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  s_axis   | in        | s_axis_tvalid/tready       | tdata step,index,value; tuser op
//  m_axis   | out       | m_axis_tvalid/tready       | tdata save
//  cfg      | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  After acceptance, load items and ticks that cannot fire go straight to the final state;
//  table ticks first compare the table entry, linear ticks run the bit-serial remainder
//  (one bit a cycle). Semilog ticks run the remainder (skipped with a zero block length),
//  then a check and up to 32 rounds of multiply, sum and check.
//  Reset clears configuration, point and table pointer; the table is not cleared.
//  A result waits in the output register while the next item is accepted; hold in
//  the final state while that register is still full.
module log_spaced_save_trigger_unit #(
  parameter int unsigned TABLE_DEPTH = lsst_pkg::TableDepthDefault,
  parameter int unsigned STEP_BITS   = lsst_pkg::StepBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] step, [41:32] table_index, [73:42] table_value, zero above
  input  logic [lsst_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] save, zero above
  output logic [lsst_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsst_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lsst_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned XW  = AW + lsst_pkg::IndexW;
  localparam int unsigned SW  = (STEP_BITS < lsst_pkg::StepW) ? STEP_BITS : lsst_pkg::StepW;
  localparam logic [lsst_pkg::StepW-1:0] StepMask =
    (SW >= lsst_pkg::StepW) ? '1 : 32'((64'd1 << SW) - 64'd1);
  localparam logic [31:0] DepthVal = 32'(TABLE_DEPTH);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StTcmp = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSchk = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StSum  = 3'd5;
  localparam logic [2:0] StChk  = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  logic [1:0]                     save_mode_q;
  logic [31:0]                    linear_period_q, log_block_q;
  logic [lsst_pkg::BaseW-1:0]     log_base_q;
  logic                           log_enable_q;

  logic [2:0]                     state_q;
  logic [lsst_pkg::PointW-1:0]    point_q;
  logic [PW-1:0]                  ptr_q;
  logic [31:0]                    step_q, rem_q, dvd_q, dvsr_q;
  logic [35:0]                    old_int_q;
  logic [56:0]                    hi_q;
  logic [36:0]                    lo_q;
  logic [5:0]                     cnt_q;
  logic                           save_q;
  logic                           out_valid_q, out_save_q;

  logic                           in_acc;
  logic [31:0]                    in_step, in_value;
  logic [lsst_pkg::IndexW-1:0]    in_index;
  logic [XW-1:0]                  idx_x;
  logic                           ram_we, ram_re;
  logic [31:0]                    ram_rdata;
  logic [32:0]                    rem_sh;
  logic [57:0]                    prod_sum;
  logic                           out_free;

  assign in_step  = s_axis_tdata[31:0] & StepMask;
  assign in_index = s_axis_tdata[41:32];
  assign in_value = s_axis_tdata[73:42];
  assign idx_x    = XW'(in_index);

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lsst_pkg::OutDataW-1){1'b0}}, out_save_q};

  assign ram_we = in_acc && (s_axis_tuser == lsst_pkg::OpLoad)
               && (32'(in_index) < DepthVal);
  assign ram_re = in_acc && (s_axis_tuser == lsst_pkg::OpTick);

  assign rem_sh   = {rem_q, dvd_q[31]};
  assign prod_sum = 58'(hi_q) + 58'(lo_q[36:16]);

  lsst_ram #(
    .Width (lsst_pkg::ValueW),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_x[AW-1:0]),
    .wdata_i (in_value),
    .re_i    (ram_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      save_mode_q     <= lsst_pkg::ModeLinear;
      linear_period_q <= '0;
      log_block_q     <= 32'd1;
      log_base_q      <= 21'd131072;
      log_enable_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lsst_pkg::CfgSaveMode:     save_mode_q     <= cfg_data_i[1:0];
        lsst_pkg::CfgLinearPeriod: linear_period_q <= cfg_data_i;
        lsst_pkg::CfgLogBlock:     log_block_q     <= cfg_data_i;
        lsst_pkg::CfgLogBase:      log_base_q      <= cfg_data_i[lsst_pkg::BaseW-1:0];
        lsst_pkg::CfgLogEnable:    log_enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      point_q     <= lsst_pkg::PointOne;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      out_save_q  <= 1'b0;
      cnt_q       <= '0;
      save_q      <= 1'b0;
      step_q      <= '0;
      rem_q       <= '0;
      dvd_q       <= '0;
      dvsr_q      <= '0;
      old_int_q   <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
    end else begin
      if (m_axis_tready && state_q != StFin) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            step_q <= in_step;
            save_q <= 1'b0;
            state_q <= StFin;
            if (s_axis_tuser == lsst_pkg::OpTick) begin
              unique case (save_mode_q)
                lsst_pkg::ModeLinear: begin
                  if (linear_period_q != '0) begin
                    dvsr_q  <= linear_period_q;
                    dvd_q   <= in_step;
                    rem_q   <= '0;
                    cnt_q   <= '0;
                    state_q <= StDiv;
                  end
                end
                lsst_pkg::ModeSemilog: begin
                  if (log_enable_q) begin
                    if (log_block_q == '0) begin
                      rem_q   <= in_step;
                      state_q <= StSchk;
                    end else begin
                      dvsr_q  <= log_block_q;
                      dvd_q   <= in_step;
                      rem_q   <= '0;
                      cnt_q   <= '0;
                      state_q <= StDiv;
                    end
                  end
                end
                lsst_pkg::ModeTable: begin
                  if (32'(ptr_q) < DepthVal) begin
                    state_q <= StTcmp;
                  end
                end
                lsst_pkg::ModeUnused: ;
                default: ;
              endcase
            end
          end
        end
        StTcmp: begin
          if (ram_rdata != '0 && step_q == ram_rdata) begin
            ptr_q  <= ptr_q + 1'b1;
            save_q <= 1'b1;
          end
          state_q <= StFin;
        end
        StDiv: begin
          rem_q <= (rem_sh >= {1'b0, dvsr_q}) ? 32'(rem_sh - {1'b0, dvsr_q}) : rem_sh[31:0];
          dvd_q <= {dvd_q[30:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd31) begin
            state_q <= (save_mode_q == lsst_pkg::ModeLinear) ? StFin : StSchk;
          end
          if (cnt_q == 6'd31 && save_mode_q == lsst_pkg::ModeLinear) begin
            save_q <= (rem_sh >= {1'b0, dvsr_q}) ? (rem_sh == {1'b0, dvsr_q})
                                                 : (rem_sh == '0);
          end
        end
        StSchk: begin
          if (36'(rem_q) == point_q[51:16] || rem_q == '0) begin
            old_int_q <= point_q[51:16];
            cnt_q     <= '0;
            state_q   <= StMul;
          end else begin
            state_q <= StFin;
          end
        end
        StMul: begin
          hi_q    <= point_q[51:16] * log_base_q;
          lo_q    <= point_q[15:0] * log_base_q;
          state_q <= StSum;
        end
        StSum: begin
          point_q <= (prod_sum > 58'(lsst_pkg::PointMax)) ? lsst_pkg::PointMax
                                                          : prod_sum[51:0];
          cnt_q   <= cnt_q + 1'b1;
          state_q <= StChk;
        end
        StChk: begin
          if (point_q[51:16] != old_int_q || point_q == lsst_pkg::PointMax
              || cnt_q == lsst_pkg::SearchLimit) begin
            if (point_q[51:16] > 36'(log_block_q)) begin
              point_q <= lsst_pkg::PointOne;
            end
            save_q  <= 1'b1;
            state_q <= StFin;
          end else begin
            state_q <= StMul;
          end
        end
        StFin: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_save_q  <= save_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for log_spaced_save_trigger_unit: directed and random
// step ticks and table loads in every save mode, checked against a local
// predictor of the save decision, under random idling on both streams.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Depth = 1024;
  localparam logic [63:0] PtOne = 64'h1_0000;
  localparam logic [63:0] PtMax = (64'd1 << 52) - 64'd1;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [lsst_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [lsst_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [lsst_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [lsst_pkg::CfgW-1:0]     cfg_data_i = '0;

  log_spaced_save_trigger_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  // predictor copy of registers and state
  logic [1:0]  mode_r;
  logic [63:0] period_r, block_r, base_r;
  logic        log_en_r;
  logic [63:0] point_r;
  logic [31:0] sched_tbl [Depth];
  bit          sched_written [Depth];
  logic [10:0] sched_ptr;

  bit          save_due_q [$];
  int unsigned send_idle, recv_idle;
  int unsigned mismatches, results_seen, ticks_sent, loads_sent, fires_seen;

  function automatic bit semilog_fire(logic [63:0] step);
    logic [63:0] pos, old_int, hi, lo, r;
    int n;
    if (!log_en_r) return 1'b0;
    pos = (block_r == 0) ? step : step % block_r;
    if (pos != (point_r >> 16) && pos != 0) return 1'b0;
    old_int = point_r >> 16;
    for (n = 0; n < 32; n++) begin
      hi = (point_r >> 16) * base_r;
      lo = (point_r & 64'hFFFF) * base_r;
      r = hi + (lo >> 16);
      point_r = (r > PtMax) ? PtMax : r;
      if ((point_r >> 16) != old_int || point_r == PtMax) break;
    end
    if ((point_r >> 16) > block_r) point_r = PtOne;
    return 1'b1;
  endfunction

  function automatic bit predict_save(logic op, logic [31:0] step, logic [9:0] idx,
                                      logic [31:0] val);
    logic [31:0] entry;
    if (op == lsst_pkg::OpLoad) begin
      sched_tbl[idx] = val;
      sched_written[idx] = 1'b1;
      return 1'b0;
    end
    case (mode_r)
      lsst_pkg::ModeLinear:  return period_r != 0 && ({32'd0, step} % period_r) == 0;
      lsst_pkg::ModeSemilog: return semilog_fire({32'd0, step});
      lsst_pkg::ModeTable: begin
        entry = (sched_ptr < Depth) ? sched_tbl[sched_ptr[9:0]] : 32'd0;
        if (entry != 0 && step == entry) begin
          sched_ptr = sched_ptr + 11'd1;
          return 1'b1;
        end
        return 1'b0;
      end
      default:     return 1'b0;
    endcase
  endfunction

  task automatic send_item(logic op, logic [31:0] step, logic [9:0] idx, logic [31:0] val);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, val, idx, step};
    do @(posedge clk_i); while (!s_axis_tready);
    save_due_q.push_back(predict_save(op, step, idx, val));
    if (op == lsst_pkg::OpLoad) loads_sent++; else ticks_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (save_due_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [lsst_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      lsst_pkg::CfgSaveMode:     mode_r   = val[1:0];
      lsst_pkg::CfgLinearPeriod: period_r = {32'd0, val};
      lsst_pkg::CfgLogBlock:     block_r  = {32'd0, val};
      lsst_pkg::CfgLogBase:      base_r   = {43'd0, val[20:0]};
      lsst_pkg::CfgLogEnable:    log_en_r = val[0];
      default: ;
    endcase
  endtask

  // keep the entry under the pointer written before any table tick reads it
  task automatic send_tick(logic [31:0] step);
    if (mode_r == lsst_pkg::ModeTable && sched_ptr < Depth
        && !sched_written[sched_ptr[9:0]])
      send_item(lsst_pkg::OpLoad, '0, sched_ptr[9:0],
                $urandom_range(7) == 0 ? 32'd0 : $urandom);
    send_item(lsst_pkg::OpTick, step, '0, '0);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (save_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result tdata=%h", m_axis_tdata);
      end else begin
        if (save_due_q[0]) fires_seen++;
        if (m_axis_tdata != {7'd0, save_due_q[0]}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("save mismatch: expected %0d actual tdata=%h", save_due_q[0], m_axis_tdata);
        end
        void'(save_due_q.pop_front());
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic test_directed;
    set_reg(lsst_pkg::CfgSaveMode, 32'(lsst_pkg::ModeLinear));
    set_reg(lsst_pkg::CfgLinearPeriod, 32'd1);
    send_tick(32'd0); send_tick(32'hFFFF_FFFF);
    set_reg(lsst_pkg::CfgLinearPeriod, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF); send_tick(32'd0); send_tick(32'd7);
    set_reg(lsst_pkg::CfgLinearPeriod, 32'd0);
    send_tick(32'd0);
    set_reg(lsst_pkg::CfgSaveMode, 32'(lsst_pkg::ModeUnused));
    send_tick(32'd0);
    send_item(lsst_pkg::OpLoad, 32'hFFFF_FFFF, 10'd0, 32'd5);
    send_item(lsst_pkg::OpLoad, '0, 10'd1023, 32'hFFFF_FFFF);
    send_item(lsst_pkg::OpLoad, '0, 10'd1, 32'd0);
    set_reg(lsst_pkg::CfgSaveMode, 32'(lsst_pkg::ModeTable));
    send_tick(32'd4); send_tick(32'd5); send_tick(32'd0);
    set_reg(lsst_pkg::CfgSaveMode, 32'(lsst_pkg::ModeSemilog));
    send_tick(32'd0);
    set_reg(lsst_pkg::CfgLogEnable, 32'd1);
    set_reg(lsst_pkg::CfgLogBlock, 32'd10);
    send_tick(32'd1); send_tick(32'd2); send_tick(32'd3); send_tick(32'd4);
    send_tick(32'd18); send_tick(32'd20);
    set_reg(lsst_pkg::CfgLogBlock, 32'd0);
    send_tick(32'd0); send_tick(32'd1);
    set_reg(lsst_pkg::CfgLogBase, 32'd0);
    send_tick(32'd0); send_tick(32'd0);
    set_reg(lsst_pkg::CfgLogBase, 32'h1F_FFFF);
    set_reg(lsst_pkg::CfgLogBlock, 32'hFFFF_FFFF);
    send_tick(32'd0); send_tick(32'd0);
  endtask

  task automatic random_config;
    logic [31:0] v;
    set_reg(lsst_pkg::CfgSaveMode,
            ($urandom_range(9) == 0) ? 32'(lsst_pkg::ModeUnused) : $urandom_range(2));
    case ($urandom_range(4))
      0: v = 32'd0;
      1: v = 32'd1;
      2: v = 32'hFFFF_FFFF;
      3: v = $urandom;
      default: v = $urandom_range(40, 2);
    endcase
    set_reg(lsst_pkg::CfgLinearPeriod, v);
    case ($urandom_range(5))
      0: v = 32'd0;
      1: v = 32'd1;
      2: v = 32'hFFFF_FFFF;
      3: v = $urandom;
      default: v = $urandom_range(300, 2);
    endcase
    set_reg(lsst_pkg::CfgLogBlock, v);
    case ($urandom_range(6))
      0: v = 32'd69632;
      1: v = 32'd1048576;
      2: v = 32'd131072;
      3: v = $urandom_range(32'h1F_FFFF);
      4: v = $urandom_range(32'hFFFF);
      default: v = $urandom_range(1048576, 69632);
    endcase
    set_reg(lsst_pkg::CfgLogBase, v);
    set_reg(lsst_pkg::CfgLogEnable, 32'($urandom_range(5) != 0));
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned i;
    logic [31:0] step, k;
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) random_config();
      k = $urandom_range(15) == 0 ? $urandom : $urandom_range(50);
      if ($urandom_range(9) == 0) begin
        send_item(lsst_pkg::OpLoad, $urandom, 10'($urandom_range(1023)),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(200));
      end else begin
        step = $urandom;
        if ($urandom_range(4) != 0) begin
          case (mode_r)
            lsst_pkg::ModeLinear: step = k * period_r[31:0];
            lsst_pkg::ModeSemilog:
              step = k * block_r[31:0] + ($urandom_range(1) ? point_r[47:16] : 32'd0);
            lsst_pkg::ModeTable:
              if (sched_ptr < Depth && sched_written[sched_ptr[9:0]])
                step = sched_tbl[sched_ptr[9:0]];
            default: ;
          endcase
        end
        send_tick(step);
      end
    end
  endtask

  initial begin
    mode_r = lsst_pkg::ModeLinear; period_r = 0; block_r = 1; base_r = 64'd131072;
    log_en_r = 0;
    point_r = PtOne; sched_ptr = '0;
    mismatches = 0; results_seen = 0; ticks_sent = 0; loads_sent = 0; fires_seen = 0;
    send_idle = 0; recv_idle = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 38; recv_idle = 77;
    test_directed();
    test_random(430);
    send_idle = 77; recv_idle = 38;
    test_random(430);
    send_idle = 0; recv_idle = 0;
    test_random(430);
    drain();
    $display("covered %0d ticks and %0d table loads, %0d saves, in all save modes",
             ticks_sent, loads_sent, fires_seen);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && save_due_q.size() == 0) begin
      $display("log_spaced_save_trigger_unit test passed");
    end else begin
      $display("log_spaced_save_trigger_unit test failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("log_spaced_save_trigger_unit test failed");
    $finish;
  end

endmodule
